### rtl/vlc_pkg.sv
package vlc_pkg;

  localparam int unsigned DefSets          = 16;
  localparam int unsigned DefVictimEntries = 4;
  localparam int unsigned DefL2Ways        = 8;
  localparam int unsigned DefBlockBytes    = 4;
  localparam int unsigned DefAgeBits       = 16;
  localparam int unsigned DefAddrBits      = 32;

  localparam int unsigned InAddrBits = 32;
  localparam int unsigned CntBits    = 32;
  localparam int unsigned NumCnt     = 6;

  typedef enum logic [2:0] {
    CNT_L1_ACC  = 3'd0,
    CNT_L1_MISS = 3'd1,
    CNT_VC_ACC  = 3'd2,
    CNT_VC_MISS = 3'd3,
    CNT_L2_ACC  = 3'd4,
    CNT_L2_MISS = 3'd5
  } vlc_cnt_e;

  typedef logic [CntBits-1:0] vlc_cnt_t;

endpackage

### rtl/vlc_if.sv
interface vlc_in_if import vlc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [InAddrBits-1:0] addr;
  modport source (output valid, op, addr, input ready);
  modport sink (input valid, op, addr, output ready);
endinterface

interface vlc_out_if import vlc_pkg::*;;
  logic     valid;
  logic     ready;
  logic     l1_hit;
  logic     victim_hit;
  logic     l2_hit;
  vlc_cnt_t l1_accesses;
  vlc_cnt_t l1_misses;
  vlc_cnt_t victim_accesses;
  vlc_cnt_t victim_misses;
  vlc_cnt_t l2_accesses;
  vlc_cnt_t l2_misses;
  modport source (output valid, l1_hit, victim_hit, l2_hit, l1_accesses, l1_misses,
                  victim_accesses, victim_misses, l2_accesses, l2_misses, input ready);
  modport sink (input valid, l1_hit, victim_hit, l2_hit, l1_accesses, l1_misses,
                victim_accesses, victim_misses, l2_accesses, l2_misses, output ready);
endinterface

### rtl/l1_victim_l2_cache_controller.sv
// An accepted item passes the lookup state, then the output state; if a victim line is
// pushed into a full victim store, it moves to l2 via an l2 row read and eviction write.
// One item at a time: a new item is taken only in idle, after the output stall clears.
// Each item reads and may rewrite its l2 set row; an eviction adds a second row access.
// reset: async active low; clears all valid bits, the event counters and the output
// valid; tag and age memories need no clearing
module l1_victim_l2_cache_controller import vlc_pkg::*; #(
  parameter int unsigned SETS           = DefSets,
  parameter int unsigned VICTIM_ENTRIES = DefVictimEntries,
  parameter int unsigned L2_WAYS        = DefL2Ways,
  parameter int unsigned BLOCK_BYTES    = DefBlockBytes,
  parameter int unsigned AGE_BITS       = DefAgeBits,
  parameter int unsigned ADDR_BITS      = DefAddrBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vlc_in_if.sink     in_i,
  vlc_out_if.source  out_o
);

  localparam int unsigned OffBits = $clog2(BLOCK_BYTES);
  localparam int unsigned SetBits = $clog2(SETS);
  localparam int unsigned BlkBits = ADDR_BITS - OffBits;
  localparam int unsigned TagBits = BlkBits - SetBits;
  localparam int unsigned ViBits  = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int unsigned WayBits = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int unsigned RowW    = TagBits + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AgeMax = {AGE_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_RD2, S_EV, S_OUT} state_e;
  typedef logic [L2_WAYS-1:0][RowW-1:0] row_t;

  function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
    return (a == AgeMax) ? AgeMax : a + 1'b1;
  endfunction

  state_e state_q;

  logic [TagBits-1:0] l1_tag_mem [SETS];
  row_t               l2_row_mem [SETS];
  logic [TagBits-1:0] l1_rd_q;
  row_t               row_q;

  logic [SETS-1:0]                 l1_valid_q;
  logic [SETS-1:0][L2_WAYS-1:0]    l2_valid_q;
  logic [VICTIM_ENTRIES-1:0]       vc_valid_q;
  logic [VICTIM_ENTRIES-1:0][BlkBits-1:0]  vc_tag_q;
  logic [VICTIM_ENTRIES-1:0][AGE_BITS-1:0] vc_age_q;
  vlc_cnt_t cnt_q [NumCnt];

  logic               op_q;
  logic [SetBits-1:0] set_q;
  logic [TagBits-1:0] tag_q;
  logic [BlkBits-1:0] vblk_q;
  logic               r_l1_q, r_vc_q, r_l2_q;

  logic [ADDR_BITS-1:0] in_a;
  logic [BlkBits-1:0]   in_blk;
  logic                 in_acc;

  assign in_a   = ADDR_BITS'(in_i.addr);
  assign in_blk = BlkBits'(in_a >> OffBits);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;

  logic [BlkBits-1:0] blk_q;
  assign blk_q = {tag_q, set_q};

  // lookup stage
  logic                 l1_hit, vc_hit, l2_hit, kicked, need_ev;
  logic [VICTIM_ENTRIES-1:0]               vv_n;
  logic [VICTIM_ENTRIES-1:0][BlkBits-1:0]  vt_n;
  logic [VICTIM_ENTRIES-1:0][AGE_BITS-1:0] va_n;
  logic [L2_WAYS-1:0]   lv_n;
  row_t                 row_n;
  logic [ViBits-1:0]    vsel;
  logic [BlkBits-1:0]   vblk_n;
  logic                 vfree;

  always_comb begin
    logic [ViBits-1:0]  vh;
    logic [WayBits-1:0] wh;
    logic               found;
    l1_hit = l1_valid_q[set_q] && (l1_rd_q == tag_q);
    vv_n   = vc_valid_q;
    vt_n   = vc_tag_q;
    va_n   = vc_age_q;
    lv_n   = l2_valid_q[set_q];
    row_n  = row_q;
    vc_hit = 1'b0;
    l2_hit = 1'b0;
    vh     = '0;
    wh     = '0;
    found  = 1'b0;
    for (int i = 0; i < VICTIM_ENTRIES; i++) begin
      if (!found && vc_valid_q[i] && vc_tag_q[i] == blk_q) begin
        found = 1'b1;
        vh    = ViBits'(i);
      end
    end
    vc_hit = found && !l1_hit;
    if (vc_hit) begin
      if (op_q) vv_n[vh] = 1'b0;
      for (int i = 0; i < VICTIM_ENTRIES; i++)
        if (vv_n[i]) va_n[i] = age_up(va_n[i]);
      if (!op_q) va_n[vh] = '0;
    end
    found = 1'b0;
    for (int i = 0; i < L2_WAYS; i++) begin
      if (!found && lv_n[i] && row_q[i][RowW-1:AGE_BITS] == tag_q) begin
        found = 1'b1;
        wh    = WayBits'(i);
      end
    end
    l2_hit = found && !l1_hit;
    if (l2_hit) begin
      if (op_q) lv_n[wh] = 1'b0;
      for (int i = 0; i < L2_WAYS; i++)
        if (lv_n[i]) row_n[i][AGE_BITS-1:0] = age_up(row_q[i][AGE_BITS-1:0]);
      if (!op_q) row_n[wh][AGE_BITS-1:0] = '0;
    end
    kicked = op_q && !l1_hit && l1_valid_q[set_q];
    vsel   = '0;
    vfree  = 1'b0;
    vblk_n = vt_n[0];
    if (kicked) begin
      for (int i = 0; i < VICTIM_ENTRIES; i++)
        if (vv_n[i]) va_n[i] = age_up(va_n[i]);
      for (int i = 1; i < VICTIM_ENTRIES; i++)
        if (va_n[i] > va_n[vsel]) vsel = ViBits'(i);
      for (int i = 0; i < VICTIM_ENTRIES; i++)
        if (!vv_n[i]) begin
          vsel  = ViBits'(i);
          vfree = 1'b1;
        end
      vblk_n     = vt_n[vsel];
      vt_n[vsel] = {l1_rd_q, set_q};
      va_n[vsel] = '0;
      vv_n[vsel] = 1'b1;
    end
    need_ev = kicked && !vfree;
  end

  // eviction into l2
  logic [SetBits-1:0] vset;
  logic [L2_WAYS-1:0] ev_v;
  row_t               ev_row;

  assign vset = vblk_q[SetBits-1:0];

  always_comb begin
    logic [WayBits-1:0] w;
    ev_v   = l2_valid_q[vset];
    ev_row = row_q;
    w      = '0;
    for (int i = 0; i < L2_WAYS; i++)
      if (ev_v[i]) ev_row[i][AGE_BITS-1:0] = age_up(row_q[i][AGE_BITS-1:0]);
    for (int i = 1; i < L2_WAYS; i++)
      if (ev_row[i][AGE_BITS-1:0] > ev_row[w][AGE_BITS-1:0]) w = WayBits'(i);
    for (int i = 0; i < L2_WAYS; i++)
      if (!ev_v[i]) w = WayBits'(i);
    ev_row[w] = {vblk_q[BlkBits-1:SetBits], {AGE_BITS{1'b0}}};
    ev_v[w]   = 1'b1;
  end

  // memories
  logic               l2_rd_en, l2_wr_en;
  logic [SetBits-1:0] l2_rd_addr, l2_wr_addr;
  row_t               l2_wr_data;

  assign l2_rd_en   = in_acc || (state_q == S_RD2);
  assign l2_rd_addr = (state_q == S_RD2) ? vset : in_blk[SetBits-1:0];
  assign l2_wr_en   = ((state_q == S_LOOK) && l2_hit) || (state_q == S_EV);
  assign l2_wr_addr = (state_q == S_EV) ? vset : set_q;
  assign l2_wr_data = (state_q == S_EV) ? ev_row : row_n;

  always_ff @(posedge clk_i) begin
    if (in_acc) l1_rd_q <= l1_tag_mem[in_blk[SetBits-1:0]];
    if (state_q == S_LOOK && op_q && !l1_hit) l1_tag_mem[set_q] <= tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (l2_rd_en) row_q <= l2_row_mem[l2_rd_addr];
    if (l2_wr_en) l2_row_mem[l2_wr_addr] <= l2_wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.op;
      set_q <= in_blk[SetBits-1:0];
      tag_q <= in_blk[BlkBits-1:SetBits];
    end
    if (state_q == S_LOOK) begin
      vblk_q <= vblk_n;
      r_l1_q <= l1_hit;
      r_vc_q <= vc_hit;
      r_l2_q <= l2_hit;
      vc_tag_q <= vt_n;
      vc_age_q <= va_n;
    end
    if (state_q == S_OUT && (!out_o.valid || out_o.ready)) begin
      out_o.l1_hit          <= r_l1_q;
      out_o.victim_hit      <= r_vc_q;
      out_o.l2_hit          <= r_l2_q;
      out_o.l1_accesses     <= cnt_q[CNT_L1_ACC];
      out_o.l1_misses       <= cnt_q[CNT_L1_MISS];
      out_o.victim_accesses <= cnt_q[CNT_VC_ACC];
      out_o.victim_misses   <= cnt_q[CNT_VC_MISS];
      out_o.l2_accesses     <= cnt_q[CNT_L2_ACC];
      out_o.l2_misses       <= cnt_q[CNT_L2_MISS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_o.valid <= 1'b0;
      l1_valid_q  <= '0;
      l2_valid_q  <= '0;
      vc_valid_q  <= '0;
      for (int k = 0; k < NumCnt; k++) cnt_q[k] <= '0;
    end else begin
      if (out_o.valid && out_o.ready && state_q != S_OUT) out_o.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_LOOK;
        end
        S_LOOK: begin
          vc_valid_q        <= vv_n;
          l2_valid_q[set_q] <= lv_n;
          if (op_q) begin
            cnt_q[CNT_L1_ACC] <= cnt_q[CNT_L1_ACC] + 1'b1;
            if (!l1_hit) begin
              l1_valid_q[set_q]  <= 1'b1;
              cnt_q[CNT_L1_MISS] <= cnt_q[CNT_L1_MISS] + 1'b1;
              cnt_q[CNT_VC_ACC]  <= cnt_q[CNT_VC_ACC] + 1'b1;
              cnt_q[CNT_L2_ACC]  <= cnt_q[CNT_L2_ACC] + 1'b1;
              if (!vc_hit) cnt_q[CNT_VC_MISS] <= cnt_q[CNT_VC_MISS] + 1'b1;
              if (!l2_hit) cnt_q[CNT_L2_MISS] <= cnt_q[CNT_L2_MISS] + 1'b1;
            end
          end
          state_q <= need_ev ? S_RD2 : S_OUT;
        end
        S_RD2: state_q <= S_EV;
        S_EV: begin
          l2_valid_q[vset] <= ev_v;
          state_q          <= S_OUT;
        end
        S_OUT: begin
          if (!out_o.valid || out_o.ready) begin
            out_o.valid <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/vlc_checker.sv
module vlc_checker import vlc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input logic     l1_hit_i,
  input logic     victim_hit_i,
  input logic     l2_hit_i,
  input vlc_cnt_t l1_misses_i,
  input vlc_cnt_t victim_accesses_i,
  input vlc_cnt_t l2_accesses_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(l1_misses_i))
    else $error("result item dropped or changed while stalled");

  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && l1_hit_i |-> !victim_hit_i && !l2_hit_i)
    else $error("lower levels flagged on an l1 hit");

  a_miss_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> l1_misses_i == victim_accesses_i && victim_accesses_i == l2_accesses_i)
    else $error("miss and probe counters diverged");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while previous item in flight");

endmodule

bind l1_victim_l2_cache_controller vlc_checker u_vlc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .l1_hit_i          (out_o.l1_hit),
  .victim_hit_i      (out_o.victim_hit),
  .l2_hit_i          (out_o.l2_hit),
  .l1_misses_i       (out_o.l1_misses),
  .victim_accesses_i (out_o.victim_accesses),
  .l2_accesses_i     (out_o.l2_accesses)
);

### tb/sv/tb_l1_victim_l2_cache_controller.sv
module tb_l1_victim_l2_cache_controller;
  import vlc_pkg::*;

  typedef struct packed {
    logic     l1_hit;
    logic     victim_hit;
    logic     l2_hit;
    vlc_cnt_t l1_accesses;
    vlc_cnt_t l1_misses;
    vlc_cnt_t victim_accesses;
    vlc_cnt_t victim_misses;
    vlc_cnt_t l2_accesses;
    vlc_cnt_t l2_misses;
  } access_res_t;

  localparam int unsigned Sets = DefSets;
  localparam int unsigned Vents = DefVictimEntries;
  localparam int unsigned Ways = DefL2Ways;
  localparam int unsigned AgeMax = (1 << DefAgeBits) - 1;

  class cache_scoreboard;
    bit          l1_v[Sets];
    logic [25:0] l1_t[Sets];
    bit          vc_v[Vents];
    logic [29:0] vc_t[Vents];
    int unsigned vc_a[Vents];
    bit          l2_v[Sets][Ways];
    logic [25:0] l2_t[Sets][Ways];
    int unsigned l2_a[Sets][Ways];
    vlc_cnt_t    cnt[NumCnt];
    access_res_t pending[$];
    int          errors;
    int          results;
    int          l1_hits, vc_hits, l2_hits;

    function int unsigned age_up(int unsigned a);
      return (a >= AgeMax) ? AgeMax : a + 1;
    endfunction

    function int vc_pick();
      int fr, old;
      fr = -1;
      old = 0;
      for (int i = 0; i < Vents; i++)
        if (vc_v[i]) vc_a[i] = age_up(vc_a[i]);
        else fr = i;
      for (int i = 1; i < Vents; i++) if (vc_a[i] > vc_a[old]) old = i;
      return (fr >= 0) ? fr : old;
    endfunction

    function int l2_pick(int s);
      int fr, old;
      fr = -1;
      old = 0;
      for (int i = 0; i < Ways; i++)
        if (l2_v[s][i]) l2_a[s][i] = age_up(l2_a[s][i]);
        else fr = i;
      for (int i = 1; i < Ways; i++) if (l2_a[s][i] > l2_a[s][old]) old = i;
      return (fr >= 0) ? fr : old;
    endfunction

    function void note_access(logic op, logic [31:0] addr);
      logic [29:0] blk, kblk, vblk;
      logic [3:0]  set, vset;
      logic [25:0] tag;
      access_res_t r;
      int          h, v, w;
      bit          ld;
      ld = op;
      blk = addr[31:2];
      set = blk[3:0];
      tag = blk[29:4];
      r = '0;
      if (ld) cnt[CNT_L1_ACC]++;
      r.l1_hit = l1_v[set] && l1_t[set] == tag;
      if (!r.l1_hit) begin
        if (ld) begin
          cnt[CNT_L1_MISS]++;
          cnt[CNT_VC_ACC]++;
        end
        h = -1;
        for (int i = 0; i < Vents; i++)
          if (h < 0 && vc_v[i] && vc_t[i] == blk) h = i;
        if (h >= 0) begin
          r.victim_hit = 1;
          if (ld) vc_v[h] = 0;
          for (int i = 0; i < Vents; i++) if (vc_v[i]) vc_a[i] = age_up(vc_a[i]);
          if (!ld) vc_a[h] = 0;
        end
        if (ld && h < 0) cnt[CNT_VC_MISS]++;
        if (ld) cnt[CNT_L2_ACC]++;
        h = -1;
        for (int i = 0; i < Ways; i++)
          if (h < 0 && l2_v[set][i] && l2_t[set][i] == tag) h = i;
        if (h >= 0) begin
          r.l2_hit = 1;
          if (ld) l2_v[set][h] = 0;
          for (int i = 0; i < Ways; i++)
            if (l2_v[set][i]) l2_a[set][i] = age_up(l2_a[set][i]);
          if (!ld) l2_a[set][h] = 0;
        end
        if (ld && h < 0) cnt[CNT_L2_MISS]++;
        if (ld) begin
          kblk = {l1_t[set], set};
          if (l1_v[set]) begin
            l1_t[set] = tag;
            v = vc_pick();
            if (!vc_v[v]) begin
              vc_t[v] = kblk;
              vc_a[v] = 0;
              vc_v[v] = 1;
            end else begin
              vblk = vc_t[v];
              vc_t[v] = kblk;
              vc_a[v] = 0;
              vset = vblk[3:0];
              w = l2_pick(vset);
              l2_t[vset][w] = vblk[29:4];
              l2_a[vset][w] = 0;
              l2_v[vset][w] = 1;
            end
          end
          l1_t[set] = tag;
          l1_v[set] = 1;
        end
      end
      r.l1_accesses = cnt[CNT_L1_ACC];
      r.l1_misses = cnt[CNT_L1_MISS];
      r.victim_accesses = cnt[CNT_VC_ACC];
      r.victim_misses = cnt[CNT_VC_MISS];
      r.l2_accesses = cnt[CNT_L2_ACC];
      r.l2_misses = cnt[CNT_L2_MISS];
      l1_hits += r.l1_hit;
      vc_hits += r.victim_hit;
      l2_hits += r.l2_hit;
      pending.push_back(r);
    endfunction

    function void check_result(access_res_t got);
      access_res_t exp_r;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp hits %b%b%b cnt %h/%h/%h/%h/%h/%h got %b%b%b %h/%h/%h/%h/%h/%h",
                   exp_r.l1_hit, exp_r.victim_hit, exp_r.l2_hit, exp_r.l1_accesses,
                   exp_r.l1_misses, exp_r.victim_accesses, exp_r.victim_misses,
                   exp_r.l2_accesses, exp_r.l2_misses, got.l1_hit, got.victim_hit,
                   got.l2_hit, got.l1_accesses, got.l1_misses, got.victim_accesses,
                   got.victim_misses, got.l2_accesses, got.l2_misses);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  vlc_in_if  in_if ();
  vlc_out_if out_if ();
  cache_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          rx_stall_free = 0;

  l1_victim_l2_cache_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("timeout");
      $display("tb_l1_victim_l2_cache_controller NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.l1_hit, out_if.victim_hit, out_if.l2_hit,
                       out_if.l1_accesses, out_if.l1_misses, out_if.victim_accesses,
                       out_if.victim_misses, out_if.l2_accesses, out_if.l2_misses});
  end

  initial begin
    int gap;
    out_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = rx_stall_free ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_if.ready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  bit tx_idle_free = 0;

  task automatic send_access(logic op, logic [31:0] addr);
    int gap;
    gap = tx_idle_free ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1;
    in_if.op <= op;
    in_if.addr <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_access(op, addr);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] mk_addr(int unsigned tg, int unsigned st);
    return {tg[25:0], st[3:0], 2'($urandom)};
  endfunction

  initial begin
    logic [31:0] a;
    in_if.valid = 0;
    in_if.op = 0;
    in_if.addr = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    send_access(1, 32'h0);
    send_access(1, 32'hffff_ffff);
    send_access(0, 32'h0);
    send_access(1, 32'h3);
    for (int t = 1; t <= 6; t++) send_access(1, mk_addr(t, 5));
    send_access(0, mk_addr(2, 5));
    send_access(0, mk_addr(1, 5));
    send_access(1, mk_addr(3, 5));
    send_access(1, mk_addr(1, 5));
    send_access(0, 32'hffff_fffc);
    send_access(0, 32'h5555_5555);
    send_access(1, 32'haaaa_aaaa);
    in_if.valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (10) @(negedge clk_i);
    for (int n = 0; n < 550; n++) begin
      tx_idle_free = (n >= 200 && n < 260);
      rx_stall_free = (n >= 230 && n < 300);
      if (n % 10 == 0) a = $urandom;
      else if ($urandom_range(0, 9) < 8)
        a = mk_addr($urandom_range(0, 11), $urandom_range(0, 2));
      else a = $urandom;
      send_access($urandom_range(0, 3) != 0, a);
      if (n == 400) begin
        in_if.valid <= 0;
        wait (sb.pending.size() == 0);
        @(negedge clk_i);
      end
    end
    in_if.valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (20) @(negedge clk_i);
    $display("accesses %0d results %0d: l1 hits %0d, victim hits %0d, l2 hits %0d",
             sb.cnt[CNT_L1_ACC], sb.results, sb.l1_hits, sb.vc_hits, sb.l2_hits);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_l1_victim_l2_cache_controller OK");
    else
      $display("tb_l1_victim_l2_cache_controller NOT OK");
    $finish;
  end
endmodule

### sim.f
rtl/vlc_pkg.sv
rtl/vlc_if.sv
rtl/l1_victim_l2_cache_controller.sv
rtl/vlc_checker.sv
tb/sv/tb_l1_victim_l2_cache_controller.sv
